// ----- design/sjf_pkg.sv -----
`default_nettype none
package sjf_pkg;

  localparam int MAX_JOBS = 16;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int IDX_W    = $clog2(MAX_JOBS);

  localparam int ID_W     = 8;
  localparam int BURST_W  = 16;
  localparam int FINISH_W = 20;
  localparam int MEAN_W   = 27;
  localparam int FRAC_W   = 8;

  // Running time and start-time sum, wide enough for a full batch.
  localparam int NOW_W    = BURST_W + CNT_W;
  localparam int WAIT_W   = BURST_W + 2 * IDX_W;
  localparam int DIV_W    = WAIT_W + FRAC_W;
  localparam int DCNT_W   = $clog2(DIV_W + 1);

  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic               dropped;
    logic               final_job;
  } job_t;

endpackage
`default_nettype wire

// ----- design/sjf_front.sv -----
`default_nettype none
module sjf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [sjf_pkg::ID_W-1:0]    proc_id_i,
  input  logic [sjf_pkg::BURST_W-1:0] burst_i,
  input  logic                last_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output sjf_pkg::job_t       push_data_o
);

  localparam int N = sjf_pkg::MAX_JOBS;

  logic [sjf_pkg::ID_W-1:0]    id_q    [N];
  logic [sjf_pkg::BURST_W-1:0] burst_q [N];
  logic [sjf_pkg::ID_W-1:0]    id_d    [N];
  logic [sjf_pkg::BURST_W-1:0] burst_d [N];
  logic [sjf_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        overflow_q, overflow_d;
  logic                        draining_q, draining_d;
  logic [N-1:0]                gt;
  logic                        in_acc, has_room, push, last_out;

  assign in_ready_o = !draining_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign has_room   = count_q < sjf_pkg::CNT_W'(N);
  assign last_out   = count_q == sjf_pkg::CNT_W'(1);

  assign push_valid_o          = draining_q;
  assign push                  = draining_q && push_ready_i;
  assign push_data_o.id        = id_q[0];
  assign push_data_o.burst     = burst_q[0];
  assign push_data_o.dropped   = overflow_q;
  assign push_data_o.final_job = last_out;

  // Empty cells count as larger than anything, so the new job lands
  // right after the last stored burst that does not exceed it.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = (sjf_pkg::CNT_W'(i) >= count_q) || (burst_q[i] > burst_i);
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      id_d[i]    = id_q[i];
      burst_d[i] = burst_q[i];
    end
    if (push) begin
      for (int i = 0; i < N - 1; i++) begin
        id_d[i]    = id_q[i+1];
        burst_d[i] = burst_q[i+1];
      end
    end else if (in_acc && has_room) begin
      if (gt[0]) begin
        id_d[0]    = proc_id_i;
        burst_d[0] = burst_i;
      end
      for (int i = 1; i < N; i++) begin
        if (gt[i]) begin
          if (!gt[i-1]) begin
            id_d[i]    = proc_id_i;
            burst_d[i] = burst_i;
          end else begin
            id_d[i]    = id_q[i-1];
            burst_d[i] = burst_q[i-1];
          end
        end
      end
    end
  end

  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    draining_d = draining_q;
    if (push) begin
      count_d = count_q - sjf_pkg::CNT_W'(1);
      if (last_out) begin
        draining_d = 1'b0;
        overflow_d = 1'b0;
      end
    end else if (in_acc) begin
      if (has_room) begin
        count_d = count_q + sjf_pkg::CNT_W'(1);
      end else begin
        overflow_d = 1'b1;
      end
      if (last_i) begin
        draining_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < N; i++) begin
      id_q[i]    <= id_d[i];
      burst_q[i] <= burst_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
      draining_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      overflow_q <= overflow_d;
      draining_q <= draining_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/sjf_queue.sv -----
`default_nettype none
module sjf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  sjf_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output sjf_pkg::job_t pop_data_o
);

  localparam int QL = sjf_pkg::QPTR_W;
  localparam int QC = sjf_pkg::QCNT_W;

  sjf_pkg::job_t   mem_q [sjf_pkg::Q_DEPTH];
  logic [QL-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QC-1:0]   cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != QC'(sjf_pkg::Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [QL-1:0] ptr_inc(input logic [QL-1:0] p);
    ptr_inc = (p == QL'(sjf_pkg::Q_DEPTH - 1)) ? '0 : p + QL'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QC'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QC'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/sjf_back.sv -----
`default_nettype none
module sjf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  sjf_pkg::job_t pop_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [sjf_pkg::ID_W-1:0]     job_id_o,
  output logic [sjf_pkg::BURST_W-1:0]  job_burst_o,
  output logic [sjf_pkg::FINISH_W-1:0] finish_time_o,
  output logic [sjf_pkg::MEAN_W-1:0]   mean_wait_q8_o,
  output logic                         dropped_o,
  output logic                         final_res_o
);

  localparam int CW = sjf_pkg::CNT_W;
  localparam int DW = sjf_pkg::DIV_W;
  localparam int KW = sjf_pkg::DCNT_W;

  logic [sjf_pkg::NOW_W-1:0]  now_q, finish_full;
  logic [sjf_pkg::WAIT_W-1:0] wsum_q, wsum_next;
  logic [CW-1:0]              n_q;
  logic                       out_valid_q, out_valid_d, busy_q;
  logic [KW-1:0]              div_cnt_q;
  logic [CW-1:0]              div_rem_q, div_den_q, rem_d;
  logic [DW-1:0]              div_quo_q, quo_d;
  logic [CW:0]                sh;
  logic                       ge, pop, div_done;

  logic [sjf_pkg::ID_W-1:0]     id_q;
  logic [sjf_pkg::BURST_W-1:0]  burst_q;
  logic [sjf_pkg::FINISH_W-1:0] finish_q;
  logic [sjf_pkg::MEAN_W-1:0]   mean_q;
  logic                         dropped_q, final_q;

  assign pop_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign pop         = pop_valid_i && pop_ready_o;
  assign finish_full = now_q + sjf_pkg::NOW_W'(pop_data_i.burst);
  assign wsum_next   = wsum_q + sjf_pkg::WAIT_W'(now_q);
  assign div_done    = busy_q && (div_cnt_q == KW'(1));

  // Restoring division, one quotient bit per cycle.
  assign sh    = {div_rem_q, div_quo_q[DW-1]};
  assign ge    = sh >= {1'b0, div_den_q};
  assign rem_d = ge ? CW'(sh - {1'b0, div_den_q}) : CW'(sh);
  assign quo_d = {div_quo_q[DW-2:0], ge};

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop && !pop_data_i.final_job) begin
      out_valid_d = 1'b1;
    end
    if (div_done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      id_q      <= pop_data_i.id;
      burst_q   <= pop_data_i.burst;
      finish_q  <= finish_full[sjf_pkg::FINISH_W-1:0];
      mean_q    <= '0;
      dropped_q <= pop_data_i.dropped;
      final_q   <= pop_data_i.final_job;
      if (pop_data_i.final_job) begin
        div_rem_q <= '0;
        div_quo_q <= {wsum_next, sjf_pkg::FRAC_W'(0)};
        div_den_q <= n_q + CW'(1);
      end
    end
    if (busy_q) begin
      div_rem_q <= rem_d;
      div_quo_q <= quo_d;
      if (div_done) begin
        mean_q <= sjf_pkg::MEAN_W'(quo_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      div_cnt_q   <= '0;
      now_q       <= '0;
      wsum_q      <= '0;
      n_q         <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        if (pop_data_i.final_job) begin
          busy_q    <= 1'b1;
          div_cnt_q <= KW'(DW);
          now_q     <= '0;
          wsum_q    <= '0;
          n_q       <= '0;
        end else begin
          now_q       <= finish_full;
          wsum_q      <= wsum_next;
          n_q         <= n_q + CW'(1);
        end
      end
      if (busy_q) begin
        div_cnt_q <= div_cnt_q - KW'(1);
        if (div_done) begin
          busy_q      <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign job_id_o       = id_q;
  assign job_burst_o    = burst_q;
  assign finish_time_o  = finish_q;
  assign mean_wait_q8_o = mean_q;
  assign dropped_o      = dropped_q;
  assign final_res_o    = final_q;

  a_busy_no_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_valid_q)
    else $error("result shown while divider runs");

  a_div_done_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |=> (out_valid_q && final_q && !busy_q))
    else $error("divider finish did not present final result");

  a_mean_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !final_q) |-> (mean_q == '0))
    else $error("mean set on non-final result");

  a_sums_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (now_q == '0 || $past(pop)))
    else $error("running time not cleared after final job");

endmodule
`default_nettype wire

// ----- design/shortest_job_first_schedule_core.sv -----
`default_nettype none
// Nonpreemptive shortest-job-first scheduler. Load a batch of up to
// sjf_pkg::MAX_JOBS jobs (id and burst), one request per cycle; the request
// with last_i set closes the batch. Jobs beyond capacity are dropped and
// every result of that batch carries dropped_o. Results come out in
// ascending burst order, stable for equal bursts, each with its finish
// time; the final one also carries the mean waiting time in unsigned Q8,
// truncated. Loading inserts each accepted job in place into the sorted
// insertion chain. After the closing request the chain drains one job per
// cycle into a two-entry queue, and input is held off until the drain
// ends; the drain stalls while the queue is full because results are
// stalled or a divide is still running. The back end emits at most one
// result per cycle; the final result waits for the bit-serial divider,
// while the front is already free to load the next batch.
module shortest_job_first_schedule_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sjf_pkg::ID_W-1:0]     proc_id_i,
  input  logic [sjf_pkg::BURST_W-1:0]  burst_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sjf_pkg::ID_W-1:0]     job_id_o,
  output logic [sjf_pkg::BURST_W-1:0]  job_burst_o,
  output logic [sjf_pkg::FINISH_W-1:0] finish_time_o,
  output logic [sjf_pkg::MEAN_W-1:0]   mean_wait_q8_o,
  output logic                         dropped_o,
  output logic                         final_res_o
);

  // Sorted jobs flow front -> queue -> back.
  logic          push_valid, push_ready;
  sjf_pkg::job_t push_data;
  logic          pop_valid, pop_ready;
  sjf_pkg::job_t pop_data;

  // Front: insert each request into the sorted chain while room remains, drain on close.
  sjf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .proc_id_i    (proc_id_i),
    .burst_i      (burst_i),
    .last_i       (last_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple the drain from result back-pressure and the divider.
  sjf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: accumulate finish and start times, divide for the mean.
  sjf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .job_id_o       (job_id_o),
    .job_burst_o    (job_burst_o),
    .finish_time_o  (finish_time_o),
    .mean_wait_q8_o (mean_wait_q8_o),
    .dropped_o      (dropped_o),
    .final_res_o    (final_res_o)
  );

endmodule
`default_nettype wire
